>>> rtl/mmfn_pkg.sv
// Shared types and operation codes of the min-max feature normaliser.
`timescale 1ns / 1ps
`default_nettype none

package mmfn_pkg;

   localparam int INDEX_BITS = 4;

   typedef logic [1:0] op_type;

   localparam op_type OP_OBSERVE   = 2'd0;
   localparam op_type OP_NORMALIZE = 2'd1;
   localparam op_type OP_CLEAR     = 2'd2;

   typedef struct packed {
      logic [INDEX_BITS-1:0] feature_index;
      op_type                op;
   } req_user_type;

   typedef struct packed {
      logic clipped;
      logic degenerate;
   } rsp_user_type;

endpackage : mmfn_pkg

`default_nettype wire

>>> rtl/min_max_feature_normalizer_unit.sv
// Top level of the min-max feature normaliser: column statistics and serial divider.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a running minimum and maximum per feature column in two small memories with a
// valid bit per column (an unwritten or cleared column reads as min = largest sample,
// max = lowest sample). Request op observe folds a sample into its column, clear drops all
// columns at once, normalize returns (value - min) / (max - min) as an unsigned fraction
// with FRACTION_BITS fraction bits, saturated and flagged as clipped outside the range and
// forced to zero and flagged as degenerate when max is not above min or the column index
// is out of range. One request is in flight at a time. A normalize that is degenerate,
// clipped or equal to the column maximum skips the divider; any other normalize runs the
// restoring divider, which produces one quotient bit per cycle for FRACTION_BITS bits.
// A finished result waits in the output register while the next request is taken; a
// normalize that finishes while that register still holds a result not yet taken stalls
// until the output accepts it.
module min_max_feature_normalizer_unit #(
   parameter int FEATURES      = 16,
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 16
) (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         req_tvalid,
   output logic                                        req_tready,
   // value
   input  wire  [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]    req_tdata,
   // op, feature_index
   input  mmfn_pkg::req_user_type                      req_tuser,
   output logic                                        rsp_tvalid,
   input  wire                                         rsp_tready,
   // normalized
   output logic [((FRACTION_BITS + 8) / 8) * 8 - 1:0]  rsp_tdata,
   // degenerate, clipped
   output mmfn_pkg::rsp_user_type                      rsp_tuser
);

   import mmfn_pkg::*;

   localparam int ADDR_BITS  = (FEATURES > 1) ? $clog2(FEATURES) : 1;
   localparam int COUNT_BITS = $clog2(FRACTION_BITS);
   localparam int RSP_BITS   = ((FRACTION_BITS + 8) / 8) * 8;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_LOW = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   logic signed [SAMPLE_BITS-1:0] min_mem [FEATURES];
   logic signed [SAMPLE_BITS-1:0] max_mem [FEATURES];
   logic [FEATURES-1:0]           col_valid_ff;

   state_type                     state_ff, state_in;
   op_type                        op_ff, op_in;
   logic                          in_range_ff, in_range_in;
   logic [ADDR_BITS-1:0]          addr_ff, addr_in;
   logic signed [SAMPLE_BITS-1:0] value_ff, value_in;
   logic signed [SAMPLE_BITS-1:0] lo_mem_ff, hi_mem_ff;
   logic                          hit_ff;
   logic [SAMPLE_BITS-1:0]        rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0]        den_ff, den_in;
   logic [FRACTION_BITS-1:0]      quot_ff, quot_in;
   logic [COUNT_BITS-1:0]         cnt_ff, cnt_in;
   logic                          top_ff, top_in;
   logic                          degen_ff, degen_in;
   logic                          clip_ff, clip_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [FRACTION_BITS:0]        rsp_norm_ff, rsp_norm_in;
   logic                          rsp_degen_ff, rsp_degen_in;
   logic                          rsp_clip_ff, rsp_clip_in;

   logic                          req_fire;
   logic                          req_in_range;
   logic [ADDR_BITS-1:0]          req_addr;
   logic signed [SAMPLE_BITS-1:0] lo_cur, hi_cur, new_min, new_max;
   logic                          v_lt_lo, v_gt_hi, v_eq_hi, degen_cur;
   logic [SAMPLE_BITS:0]          rem_shift, rem_sub;
   logic                          rem_ge;
   logic                          rsp_free;

   assign req_tready   = (state_ff == ST_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign req_in_range = (32'(req_tuser.feature_index) < FEATURES);
   assign req_addr     = ADDR_BITS'(req_tuser.feature_index);

   assign lo_cur    = hit_ff ? lo_mem_ff : SAMPLE_TOP;
   assign hi_cur    = hit_ff ? hi_mem_ff : SAMPLE_LOW;
   assign v_lt_lo   = (value_ff < lo_cur);
   assign v_gt_hi   = (value_ff > hi_cur);
   assign v_eq_hi   = (value_ff == hi_cur);
   assign degen_cur = !in_range_ff || (hi_cur <= lo_cur);
   assign new_min   = v_lt_lo ? value_ff : lo_cur;
   assign new_max   = v_gt_hi ? value_ff : hi_cur;

   assign rem_shift = {rem_ff, 1'b0};
   assign rem_sub   = rem_shift - {1'b0, den_ff};
   assign rem_ge    = (rem_shift >= {1'b0, den_ff});

   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (req_fire && req_in_range) begin
         lo_mem_ff <= min_mem[req_addr];
         hi_mem_ff <= max_mem[req_addr];
         hit_ff    <= col_valid_ff[req_addr];
      end else if (req_fire) begin
         hit_ff    <= 1'b0;
      end
      if (state_ff == ST_EVAL && op_ff == OP_OBSERVE && in_range_ff) begin
         min_mem[addr_ff] <= new_min;
         max_mem[addr_ff] <= new_max;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_valid_ff <= '0;
      end else if (state_ff == ST_EVAL && op_ff == OP_CLEAR) begin
         col_valid_ff <= '0;
      end else if (state_ff == ST_EVAL && op_ff == OP_OBSERVE && in_range_ff) begin
         col_valid_ff[addr_ff] <= 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      in_range_in  = in_range_ff;
      addr_in      = addr_ff;
      value_in     = value_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      top_in       = top_ff;
      degen_in     = degen_ff;
      clip_in      = clip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_norm_in  = rsp_norm_ff;
      rsp_degen_in = rsp_degen_ff;
      rsp_clip_in  = rsp_clip_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in       = req_tuser.op;
               in_range_in = req_in_range;
               addr_in     = req_addr;
               value_in    = req_tdata[SAMPLE_BITS-1:0];
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            case (op_ff)
               OP_NORMALIZE: begin
                  quot_in  = '0;
                  top_in   = 1'b0;
                  degen_in = 1'b0;
                  clip_in  = 1'b0;
                  state_in = ST_DONE;
                  if (degen_cur) begin
                     degen_in = 1'b1;
                  end else if (v_lt_lo) begin
                     clip_in = 1'b1;
                  end else if (v_gt_hi) begin
                     top_in  = 1'b1;
                     clip_in = 1'b1;
                  end else if (v_eq_hi) begin
                     top_in = 1'b1;
                  end else begin
                     rem_in   = SAMPLE_BITS'(value_ff - lo_cur);
                     den_in   = SAMPLE_BITS'(hi_cur - lo_cur);
                     cnt_in   = COUNT_BITS'(FRACTION_BITS - 1);
                     state_in = ST_DIVIDE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_DIVIDE: begin
            rem_in  = rem_ge ? rem_sub[SAMPLE_BITS-1:0] : rem_shift[SAMPLE_BITS-1:0];
            quot_in = {quot_ff[FRACTION_BITS-2:0], rem_ge};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_norm_in  = {top_ff, quot_ff};
               rsp_degen_in = degen_ff;
               rsp_clip_in  = clip_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      in_range_ff  <= in_range_in;
      addr_ff      <= addr_in;
      value_ff     <= value_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      quot_ff      <= quot_in;
      cnt_ff       <= cnt_in;
      top_ff       <= top_in;
      degen_ff     <= degen_in;
      clip_ff      <= clip_in;
      rsp_norm_ff  <= rsp_norm_in;
      rsp_degen_ff <= rsp_degen_in;
      rsp_clip_ff  <= rsp_clip_in;
   end

   assign rsp_tvalid           = rsp_valid_ff;
   assign rsp_tdata            = RSP_BITS'(rsp_norm_ff);
   assign rsp_tuser.degenerate = rsp_degen_ff;
   assign rsp_tuser.clipped    = rsp_clip_ff;

endmodule : min_max_feature_normalizer_unit

`default_nettype wire

>>> rtl/mmfn_checker.sv
// Port-level checks of the min-max feature normaliser and their binding.
`timescale 1ns / 1ps
`default_nettype none

module mmfn_checker #(
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 16
) (
   input wire                                         clock,
   input wire                                         reset,
   input wire                                         req_tvalid,
   input wire                                         req_tready,
   // value
   input wire [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]     req_tdata,
   // op, feature_index
   input mmfn_pkg::req_user_type                      req_tuser,
   input wire                                         rsp_tvalid,
   input wire                                         rsp_tready,
   // normalized
   input wire [((FRACTION_BITS + 8) / 8) * 8 - 1:0]   rsp_tdata,
   // degenerate, clipped
   input mmfn_pkg::rsp_user_type                      rsp_tuser
);

   import mmfn_pkg::*;

   localparam int RSP_BITS = ((FRACTION_BITS + 8) / 8) * 8;
   localparam logic [RSP_BITS-1:0] ONE_FRACTION = RSP_BITS'(1) << FRACTION_BITS;

   logic req_fire;
   logic unused_ok;

   assign req_fire  = req_tvalid && req_tready;
   assign unused_ok = ^{req_tdata, req_tuser};

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser.degenerate |-> rsp_tdata == '0 && !rsp_tuser.clipped)
      else $error("degenerate response not zero or also clipped");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser.clipped |-> rsp_tdata == '0 || rsp_tdata == ONE_FRACTION)
      else $error("clipped response not saturated");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= ONE_FRACTION)
      else $error("normalised value above one");

   assert property (@(posedge clock) disable iff (reset)
      req_fire && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response raised one cycle after a request");

endmodule : mmfn_checker

bind min_max_feature_normalizer_unit mmfn_checker #(
   .SAMPLE_BITS   (SAMPLE_BITS),
   .FRACTION_BITS (FRACTION_BITS)
) u_mmfn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

>>> tb/min_max_feature_normalizer_unit_tb.sv
// Self-checking testbench of the min-max feature normaliser with directed and random requests.
`timescale 1ns / 1ps
`default_nettype none

module min_max_feature_normalizer_unit_tb;

   import mmfn_pkg::*;

   localparam int          COLUMNS         = 16;
   localparam logic [16:0] FULL_SCALE      = 17'h10000;
   localparam op_type      OP_UNDEFINED    = 2'd3;
   localparam int          RANDOM_REQUESTS = 1200;
   localparam int          HOLD_OFF_CYCLES = 400;
   localparam int          SETTLE_CYCLES   = 40;
   localparam int          LIMIT_NS        = 4_000_000;
   localparam int          DIRECTED_ROWS   = 25;

   typedef struct packed {
      logic [16:0] normalized;
      logic        degenerate;
      logic        clipped;
   } norm_result;

   typedef struct {
      op_type             op;
      logic [3:0]         column;
      logic signed [15:0] sample;
      bit                 typed;
      logic [16:0]        normalized;
      logic               degenerate;
      logic               clipped;
   } directed_row;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [15:0]  req_tdata;
   req_user_type req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [23:0]  rsp_tdata;
   rsp_user_type rsp_tuser;

   logic signed [15:0] seen_min [COLUMNS];
   logic signed [15:0] seen_max [COLUMNS];
   int                 sample_span [COLUMNS];
   norm_result         pending_results [$];
   int                 mismatch_count;
   int                 burst_left;
   bit                 hold_off_request;
   directed_row        directed_rows [DIRECTED_ROWS];

   min_max_feature_normalizer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("[min_max_feature_normalizer_unit] ERROR");
      $finish;
   end

   function automatic norm_result predict_normalized(input logic [3:0] column,
                                                     input logic signed [15:0] sample);
      norm_result r;
      int         lo;
      int         hi;
      int         v;
      int         remainder;
      int         b;
      r  = '0;
      lo = seen_min[column];
      hi = seen_max[column];
      v  = sample;
      if (hi <= lo) begin
         r.degenerate = 1'b1;
      end else if (v < lo) begin
         r.clipped = 1'b1;
      end else if (v > hi) begin
         r.normalized = FULL_SCALE;
         r.clipped    = 1'b1;
      end else if (v == hi) begin
         r.normalized = FULL_SCALE;
      end else begin
         remainder = v - lo;
         for (b = 0; b < 16; b++) begin
            remainder    = remainder * 2;
            r.normalized = r.normalized << 1;
            if (remainder >= hi - lo) begin
               remainder       = remainder - (hi - lo);
               r.normalized[0] = 1'b1;
            end
         end
      end
      return r;
   endfunction

   task automatic clear_statistics();
      int i;
      for (i = 0; i < COLUMNS; i++) begin
         seen_min[i]    = 16'sh7fff;
         seen_max[i]    = 16'sh8000;
         sample_span[i] = 1 << $urandom_range(1, 14);
      end
   endtask

   function automatic logic signed [15:0] pick_sample(input logic [3:0] column);
      int lo;
      int hi;
      int s;
      int v;
      lo = seen_min[column];
      hi = seen_max[column];
      s  = sample_span[column];
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = int'($urandom_range(0, 2 * s)) - s;
         4: v = int'($urandom_range(0, 65535)) - 32768;
         5: begin
            case ($urandom_range(0, 3))
               0: v = -32768;
               1: v = 32767;
               2: v = 0;
               default: v = -1;
            endcase
         end
         6, 7: v = (hi > lo) ? lo + int'($urandom_range(0, hi - lo)) : s;
         8: v = $urandom_range(0, 1) ? lo : hi;
         default: v = $urandom_range(0, 1) ? lo - 1 : hi + 1;
      endcase
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return v[15:0];
   endfunction

   task automatic send_request(input op_type op, input logic [3:0] column,
                               input logic signed [15:0] sample, input bit typed,
                               input norm_result typed_result);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tuser  <= '{feature_index: column, op: op};
      do @(posedge clock); while (!req_tready);
      case (op)
         OP_OBSERVE: begin
            if (sample < seen_min[column]) seen_min[column] = sample;
            if (sample > seen_max[column]) seen_max[column] = sample;
         end
         OP_NORMALIZE: begin
            pending_results.push_back(typed ? typed_result : predict_normalized(column, sample));
         end
         OP_CLEAR: clear_statistics();
         default: ;
      endcase
   endtask

   // hold the input idle until every result is back
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", what);
   endtask

   always @(posedge clock) begin
      norm_result want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            note_mismatch($sformatf("unexpected result normalized=%0d degenerate=%0b clipped=%0b",
                                    rsp_tdata, rsp_tuser.degenerate, rsp_tuser.clipped));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== {7'd0, want.normalized} ||
                rsp_tuser.degenerate !== want.degenerate ||
                rsp_tuser.clipped !== want.clipped) begin
               note_mismatch($sformatf(
                  "expected normalized=%0d degenerate=%0b clipped=%0b, got %0d %0b %0b",
                  want.normalized, want.degenerate, want.clipped,
                  rsp_tdata, rsp_tuser.degenerate, rsp_tuser.clipped));
            end
         end
      end
   end

   initial begin
      int window_left;
      int mode;
      window_left = 0;
      mode        = 0;
      rsp_tready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_request = 1'b0;
         end else begin
            if (window_left == 0) begin
               mode        = $urandom_range(0, 3);
               window_left = $urandom_range(8, 64);
            end
            window_left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   initial begin
      int         n;
      int         pick;
      op_type     op;
      logic [3:0] column;
      norm_result typed_result;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = '0;
      mismatch_count   = 0;
      burst_left       = 0;
      hold_off_request = 1'b0;
      clear_statistics();

      directed_rows = '{
         '{OP_NORMALIZE, 4'd0,  16'sd0,      1'b1, 17'd0,      1'b1, 1'b0},
         '{OP_NORMALIZE, 4'd15, -16'sd32768, 1'b1, 17'd0,      1'b1, 1'b0},
         '{OP_OBSERVE,   4'd0,  -16'sd32768, 1'b0, 17'd0,      1'b0, 1'b0},
         '{OP_NORMALIZE, 4'd0,  -16'sd32768, 1'b1, 17'd0,      1'b1, 1'b0},
         '{OP_OBSERVE,   4'd0,  16'sd32767,  1'b0, 17'd0,      1'b0, 1'b0},
         '{OP_NORMALIZE, 4'd0,  16'sd32767,  1'b1, FULL_SCALE, 1'b0, 1'b0},
         '{OP_NORMALIZE, 4'd0,  -16'sd32768, 1'b1, 17'd0,      1'b0, 1'b0},
         '{OP_NORMALIZE, 4'd0,  16'sd0,      1'b0, 17'd0,      1'b0, 1'b0},
         '{OP_NORMALIZE, 4'd0,  -16'sd1,     1'b0, 17'd0,      1'b0, 1'b0},
         '{OP_OBSERVE,   4'd3,  16'sd100,    1'b0, 17'd0,      1'b0, 1'b0},
         '{OP_OBSERVE,   4'd3,  16'sd200,    1'b0, 17'd0,      1'b0, 1'b0},
         '{OP_UNDEFINED, 4'd3,  16'sd1000,   1'b0, 17'd0,      1'b0, 1'b0},
         '{OP_NORMALIZE, 4'd3,  16'sd201,    1'b1, FULL_SCALE, 1'b0, 1'b1},
         '{OP_NORMALIZE, 4'd3,  16'sd99,     1'b1, 17'd0,      1'b0, 1'b1},
         '{OP_NORMALIZE, 4'd3,  16'sd150,    1'b0, 17'd0,      1'b0, 1'b0},
         '{OP_NORMALIZE, 4'd3,  16'sd101,    1'b0, 17'd0,      1'b0, 1'b0},
         '{OP_NORMALIZE, 4'd3,  16'sd199,    1'b0, 17'd0,      1'b0, 1'b0},
         '{OP_OBSERVE,   4'd15, 16'sd32767,  1'b0, 17'd0,      1'b0, 1'b0},
         '{OP_NORMALIZE, 4'd15, 16'sd32767,  1'b1, 17'd0,      1'b1, 1'b0},
         '{OP_OBSERVE,   4'd15, 16'sd32766,  1'b0, 17'd0,      1'b0, 1'b0},
         '{OP_NORMALIZE, 4'd15, 16'sd32766,  1'b1, 17'd0,      1'b0, 1'b0},
         '{OP_CLEAR,     4'd0,  16'sd0,      1'b0, 17'd0,      1'b0, 1'b0},
         '{OP_NORMALIZE, 4'd3,  16'sd150,    1'b1, 17'd0,      1'b1, 1'b0},
         '{OP_OBSERVE,   4'd7,  -16'sd5,     1'b0, 17'd0,      1'b0, 1'b0},
         '{OP_NORMALIZE, 4'd7,  -16'sd6,     1'b1, 17'd0,      1'b1, 1'b0}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         typed_result = '{directed_rows[i].normalized, directed_rows[i].degenerate,
                          directed_rows[i].clipped};
         send_request(directed_rows[i].op, directed_rows[i].column, directed_rows[i].sample,
                      directed_rows[i].typed, typed_result);
      end
      drain_results();

      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == 300) hold_off_request = 1'b1;
         if (n == 800) drain_results();
         pick   = $urandom_range(0, 99);
         column = 4'($urandom_range(0, COLUMNS - 1));
         if (pick < 2) op = OP_CLEAR;
         else if (pick < 4) op = OP_UNDEFINED;
         else if (pick < 50) op = OP_OBSERVE;
         else op = OP_NORMALIZE;
         send_request(op, column, pick_sample(column), 1'b0, '0);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("[min_max_feature_normalizer_unit] OK");
      end else begin
         $display("[min_max_feature_normalizer_unit] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
